// ===== sv/dmrb_pkg.sv =====
// ----------------------------------------------------------------------------
// dmrb_pkg
// Shared types and constants for the dual motor ramp and boost PWM core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dmrb_pkg;

    // request codes
    localparam logic [1:0] MODE_SET  = 2'd0;
    localparam logic [1:0] MODE_TICK = 2'd1;
    localparam logic [1:0] MODE_STOP = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_RAMP_INTERVAL = 3'd0;
    localparam logic [2:0] REG_RAMP_STEP     = 3'd1;
    localparam logic [2:0] REG_BOOST_DUR     = 3'd2;
    localparam logic [2:0] REG_BOOST_SPEED   = 3'd3;
    localparam logic [2:0] REG_PWM_MAX       = 3'd4;
    localparam logic [2:0] REG_MIN_ROT       = 3'd5;
    localparam logic [2:0] REG_MIN_DRV       = 3'd6;

    // full scale speed in percent
    localparam logic [6:0]        SPEED_FULL     = 7'd100;
    localparam logic signed [7:0] SPEED_POS_FULL = 8'sd100;
    localparam logic signed [7:0] SPEED_NEG_FULL = -8'sd100;

    // divide by 100 for products below 2**23: multiply by ceil(2**30 / 100)
    localparam logic [23:0] DIV100_RECIP = 24'd10737419;
    localparam int          DIV100_SHIFT = 30;

    typedef struct packed {
        logic load_mul;
        logic load_div;
    } pipe_en_t;

endpackage

`default_nettype wire

// ===== sv/dmrb_level.sv =====
// ----------------------------------------------------------------------------
// dmrb_level
// Two-stage PWM level path for one motor: deadband and scale, then divide
// by 100 and route to the forward or reverse pin.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmrb_level (
    input  wire                   clk,
    input  wire dmrb_pkg::pipe_en_t en,
    input  wire logic signed [7:0] speed,
    input  wire logic [6:0]        deadband_min,
    input  wire logic [15:0]       pwm_max,
    output logic [15:0]            fwd_level,
    output logic [15:0]            rev_level
);

    logic [6:0]  mag;
    logic [6:0]  min_cap;
    logic [6:0]  eff;
    logic [22:0] prod_next;
    logic [22:0] prod_reg;
    logic        neg_reg;
    logic [46:0] quot_full;
    logic [15:0] lvl;
    logic [15:0] fwd_reg;
    logic [15:0] rev_reg;

    always_comb
    begin
        mag     = speed[7] ? 7'(-speed) : speed[6:0];
        min_cap = (deadband_min > dmrb_pkg::SPEED_FULL) ? dmrb_pkg::SPEED_FULL
                                                        : deadband_min;
        if (mag == 7'd0)
        begin
            eff = 7'd0;
        end
        else
        begin
            eff = (mag < min_cap) ? min_cap : mag;
        end
        prod_next = 23'(eff) * 23'(pwm_max);
    end

    always_ff @(posedge clk)
    begin
        if (en.load_mul)
        begin
            prod_reg <= prod_next;
            neg_reg  <= speed[7];
        end
    end

    always_comb
    begin
        quot_full = 47'(prod_reg) * 47'(dmrb_pkg::DIV100_RECIP);
        lvl       = quot_full[dmrb_pkg::DIV100_SHIFT +: 16];
    end

    always_ff @(posedge clk)
    begin
        if (en.load_div)
        begin
            fwd_reg <= neg_reg ? 16'd0 : lvl;
            rev_reg <= neg_reg ? lvl : 16'd0;
        end
    end

    assign fwd_level = fwd_reg;
    assign rev_level = rev_reg;

endmodule

`default_nettype wire

// ===== sv/dual_motor_ramp_boost_pwm_core.sv =====
// ----------------------------------------------------------------------------
// dual_motor_ramp_boost_pwm_core
// Rotation and drive H-bridge controller with speed ramp, drive boost and
// deadband-limited PWM levels.
//
// Requests enter on item_valid/item_ready: mode (set speed, 1 ms tick, stop
// all), motor_select and a signed speed. Every request yields one result on
// result_valid/result_ready: four PWM levels, both applied speeds and the
// boost flag, all taken after that request's update.
// Registers are written on cfg_valid/cfg_ready (always ready) by index;
// write only while no request is in flight.
// The path is four register stages: input register, motor state, scale
// multiply, divide-by-100 multiply into the result register. One request is
// taken per cycle while the result register is not stalled.
// The two multiplier stages per motor set the stage count.
// When the receiver stalls, the result register holds and the stages behind
// it fill; item_ready drops only once all four stages hold requests.
// Reset clears all motor state, counters and valid flags and loads the
// register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dual_motor_ramp_boost_pwm_core (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    item_valid,
    output logic                   item_ready,
    input  wire logic [1:0]        mode,
    input  wire logic              motor_select,
    input  wire logic signed [7:0] speed,
    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [15:0]       cfg_data,
    output logic                   result_valid,
    input  wire                    result_ready,
    output logic [15:0]            rot_fwd_level,
    output logic [15:0]            rot_rev_level,
    output logic [15:0]            drv_fwd_level,
    output logic [15:0]            drv_rev_level,
    output logic signed [7:0]      rot_speed_now,
    output logic signed [7:0]      drv_speed_now,
    output logic                   boosting
);

    // configuration
    logic [15:0] ramp_interval_reg;
    logic [7:0]  ramp_step_reg;
    logic [15:0] boost_dur_reg;
    logic [6:0]  boost_speed_reg;
    logic [15:0] pwm_max_reg;
    logic [6:0]  min_rot_reg;
    logic [6:0]  min_drv_reg;

    // stage valids and handshake
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s4_valid_reg;
    logic rdy4;
    logic rdy3;
    logic rdy2;
    logic rdy1;
    dmrb_pkg::pipe_en_t rot_en;
    dmrb_pkg::pipe_en_t drv_en;

    // input register
    logic [1:0]        mode_reg;
    logic              sel_reg;
    logic signed [7:0] speed_reg;

    // motor state
    logic signed [7:0] rot_target_reg;
    logic signed [7:0] rot_target_next;
    logic signed [7:0] drv_target_reg;
    logic signed [7:0] drv_target_next;
    logic signed [7:0] rot_current_reg;
    logic signed [7:0] rot_current_next;
    logic signed [7:0] drv_current_reg;
    logic signed [7:0] drv_current_next;
    logic              boost_on_reg;
    logic              boost_on_next;
    logic [15:0]       interval_count_reg;
    logic [15:0]       interval_count_next;
    logic [15:0]       boost_elapsed_reg;
    logic [15:0]       boost_elapsed_next;

    // stage 3 and 4 carried fields
    logic signed [7:0] rot_s3_reg;
    logic signed [7:0] drv_s3_reg;
    logic              boost_s3_reg;
    logic signed [7:0] rot_s4_reg;
    logic signed [7:0] drv_s4_reg;
    logic              boost_s4_reg;

    // update datapath
    logic signed [7:0] spd_clamp;
    logic [15:0]       count_inc;
    logic signed [8:0] diff;
    logic [8:0]        abs_diff;
    logic signed [8:0] step9;
    logic signed [8:0] rot_step_up;
    logic signed [8:0] rot_step_dn;
    logic [6:0]        boost_cap;
    logic signed [7:0] boost_pos;
    logic              load_state;

    // handshake chain
    assign rdy4       = !s4_valid_reg || result_ready;
    assign rdy3       = !s3_valid_reg || rdy4;
    assign rdy2       = !s2_valid_reg || rdy3;
    assign rdy1       = !s1_valid_reg || rdy2;
    assign item_ready = rdy1;
    assign load_state = s1_valid_reg && rdy2;

    assign rot_en.load_mul = s2_valid_reg && rdy3;
    assign rot_en.load_div = s3_valid_reg && rdy4;
    assign drv_en          = rot_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_valid_reg <= item_valid;
            end
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (rdy4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_interval_reg <= 16'd20;
            ramp_step_reg     <= 8'd5;
            boost_dur_reg     <= 16'd200;
            boost_speed_reg   <= 7'd100;
            pwm_max_reg       <= 16'd1000;
            min_rot_reg       <= 7'd20;
            min_drv_reg       <= 7'd65;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dmrb_pkg::REG_RAMP_INTERVAL: ramp_interval_reg <= cfg_data;
                dmrb_pkg::REG_RAMP_STEP:     ramp_step_reg     <= cfg_data[7:0];
                dmrb_pkg::REG_BOOST_DUR:     boost_dur_reg     <= cfg_data;
                dmrb_pkg::REG_BOOST_SPEED:   boost_speed_reg   <= cfg_data[6:0];
                dmrb_pkg::REG_PWM_MAX:       pwm_max_reg       <= cfg_data;
                dmrb_pkg::REG_MIN_ROT:       min_rot_reg       <= cfg_data[6:0];
                dmrb_pkg::REG_MIN_DRV:       min_drv_reg       <= cfg_data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (item_valid && rdy1)
        begin
            mode_reg  <= mode;
            sel_reg   <= motor_select;
            speed_reg <= speed;
        end
    end

    // motor state update
    always_comb
    begin
        rot_target_next     = rot_target_reg;
        drv_target_next     = drv_target_reg;
        rot_current_next    = rot_current_reg;
        drv_current_next    = drv_current_reg;
        boost_on_next       = boost_on_reg;
        interval_count_next = interval_count_reg;
        boost_elapsed_next  = boost_elapsed_reg;

        if (speed_reg < dmrb_pkg::SPEED_NEG_FULL)
        begin
            spd_clamp = dmrb_pkg::SPEED_NEG_FULL;
        end
        else if (speed_reg > dmrb_pkg::SPEED_POS_FULL)
        begin
            spd_clamp = dmrb_pkg::SPEED_POS_FULL;
        end
        else
        begin
            spd_clamp = speed_reg;
        end

        count_inc   = interval_count_reg + 16'd1;
        diff        = 9'(rot_current_reg) - 9'(rot_target_reg);
        abs_diff    = diff[8] ? 9'(-diff) : 9'(diff);
        step9       = $signed({1'b0, ramp_step_reg});
        rot_step_up = 9'(rot_current_reg) + step9;
        rot_step_dn = 9'(rot_current_reg) - step9;
        boost_cap   = (boost_speed_reg > dmrb_pkg::SPEED_FULL) ? dmrb_pkg::SPEED_FULL
                                                               : boost_speed_reg;
        boost_pos   = $signed({1'b0, boost_cap});

        unique case (mode_reg)
            dmrb_pkg::MODE_SET:
            begin
                if (!sel_reg)
                begin
                    rot_target_next = spd_clamp;
                    if (spd_clamp != 8'sd0 && drv_current_reg != 8'sd0)
                    begin
                        drv_target_next  = 8'sd0;
                        drv_current_next = 8'sd0;
                    end
                end
                else
                begin
                    drv_target_next = spd_clamp;
                    if (spd_clamp != 8'sd0 && rot_current_reg != 8'sd0)
                    begin
                        rot_target_next  = 8'sd0;
                        rot_current_next = 8'sd0;
                    end
                    if (drv_current_reg == 8'sd0 && spd_clamp != 8'sd0)
                    begin
                        boost_on_next      = 1'b1;
                        boost_elapsed_next = 16'd0;
                    end
                end
            end
            dmrb_pkg::MODE_TICK:
            begin
                if (boost_elapsed_reg != 16'hFFFF)
                begin
                    boost_elapsed_next = boost_elapsed_reg + 16'd1;
                end
                interval_count_next = count_inc;
                if (count_inc >= ramp_interval_reg)
                begin
                    interval_count_next = 16'd0;
                    // rotation ramp
                    if (abs_diff <= {1'b0, ramp_step_reg})
                    begin
                        rot_current_next = rot_target_reg;
                    end
                    else if (rot_current_reg < rot_target_reg)
                    begin
                        rot_current_next = rot_step_up[7:0];
                    end
                    else
                    begin
                        rot_current_next = rot_step_dn[7:0];
                    end
                    // drive boost or jump
                    if (boost_on_reg)
                    begin
                        if (boost_elapsed_next >= boost_dur_reg)
                        begin
                            boost_on_next    = 1'b0;
                            drv_current_next = drv_target_reg;
                        end
                        else
                        begin
                            drv_current_next = drv_target_reg[7] ? 8'(-boost_pos) : boost_pos;
                        end
                    end
                    else
                    begin
                        drv_current_next = drv_target_reg;
                    end
                end
            end
            dmrb_pkg::MODE_STOP:
            begin
                rot_target_next  = 8'sd0;
                drv_target_next  = 8'sd0;
                rot_current_next = 8'sd0;
                drv_current_next = 8'sd0;
                boost_on_next    = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_target_reg     <= 8'sd0;
            drv_target_reg     <= 8'sd0;
            rot_current_reg    <= 8'sd0;
            drv_current_reg    <= 8'sd0;
            boost_on_reg       <= 1'b0;
            interval_count_reg <= 16'd0;
            boost_elapsed_reg  <= 16'd0;
        end
        else if (load_state)
        begin
            rot_target_reg     <= rot_target_next;
            drv_target_reg     <= drv_target_next;
            rot_current_reg    <= rot_current_next;
            drv_current_reg    <= drv_current_next;
            boost_on_reg       <= boost_on_next;
            interval_count_reg <= interval_count_next;
            boost_elapsed_reg  <= boost_elapsed_next;
        end
    end

    // speeds and flag ride along the level path
    always_ff @(posedge clk)
    begin
        if (rot_en.load_mul)
        begin
            rot_s3_reg   <= rot_current_reg;
            drv_s3_reg   <= drv_current_reg;
            boost_s3_reg <= boost_on_reg;
        end
        if (rot_en.load_div)
        begin
            rot_s4_reg   <= rot_s3_reg;
            drv_s4_reg   <= drv_s3_reg;
            boost_s4_reg <= boost_s3_reg;
        end
    end

    dmrb_level u_rot_level (
        .clk          (clk),
        .en           (rot_en),
        .speed        (rot_current_reg),
        .deadband_min (min_rot_reg),
        .pwm_max      (pwm_max_reg),
        .fwd_level    (rot_fwd_level),
        .rev_level    (rot_rev_level)
    );

    dmrb_level u_drv_level (
        .clk          (clk),
        .en           (drv_en),
        .speed        (drv_current_reg),
        .deadband_min (min_drv_reg),
        .pwm_max      (pwm_max_reg),
        .fwd_level    (drv_fwd_level),
        .rev_level    (drv_rev_level)
    );

    assign result_valid  = s4_valid_reg;
    assign rot_speed_now = rot_s4_reg;
    assign drv_speed_now = drv_s4_reg;
    assign boosting      = boost_s4_reg;

endmodule

`default_nettype wire

// ===== sv/dmrb_checker.sv =====
// ----------------------------------------------------------------------------
// dmrb_checker
// Port-level checks for the dual motor ramp and boost PWM core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmrb_checker (
    input wire                    clk,
    input wire                    rst_n,
    input wire                    result_valid,
    input wire                    result_ready,
    input wire logic [15:0]       rot_fwd_level,
    input wire logic [15:0]       rot_rev_level,
    input wire logic [15:0]       drv_fwd_level,
    input wire logic [15:0]       drv_rev_level,
    input wire logic signed [7:0] rot_speed_now,
    input wire logic signed [7:0] drv_speed_now
);

    // a stalled result stays up
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its forward levels
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(rot_fwd_level) && $stable(drv_fwd_level))
        else $error("result levels changed while stalled");

    // only one pin of each bridge is driven
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (rot_fwd_level == 16'd0 || rot_rev_level == 16'd0)
                      && (drv_fwd_level == 16'd0 || drv_rev_level == 16'd0))
        else $error("both bridge pins driven");

    // with both motors stopped, no bridge pin gets drive
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && rot_speed_now == 8'sd0 && drv_speed_now == 8'sd0
        |-> rot_fwd_level == 16'd0 && rot_rev_level == 16'd0
         && drv_fwd_level == 16'd0 && drv_rev_level == 16'd0)
        else $error("level on a stopped motor");

    // a reverse speed never drives the forward pin
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (rot_speed_now < 8'sd0 || drv_speed_now < 8'sd0)
        |-> (rot_speed_now >= 8'sd0 || rot_fwd_level == 16'd0)
         && (drv_speed_now >= 8'sd0 || drv_fwd_level == 16'd0))
        else $error("forward pin driven in reverse");

endmodule

bind dual_motor_ramp_boost_pwm_core dmrb_checker u_dmrb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .rot_fwd_level (rot_fwd_level),
    .rot_rev_level (rot_rev_level),
    .drv_fwd_level (drv_fwd_level),
    .drv_rev_level (drv_rev_level),
    .rot_speed_now (rot_speed_now),
    .drv_speed_now (drv_speed_now)
);

`default_nettype wire
